### hdl/mwpb_pkg.sv
// ============================================================================
// Masked wipe pixel blender package
// Shared widths, stage layout and codes for the wipe blender and its
// channel interfaces.
// ============================================================================
package mwpb_pkg;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = PIX_W / CH_W;
    localparam int MASK_W     = 8;
    localparam int THR_W      = 11;
    // Sign-extended working width for threshold and mask arithmetic.
    localparam int ARITH_W    = THR_W + 1;
    // Divisor (high - low) is at most 2047 when a division is needed.
    localparam int DEN_W      = THR_W;
    localparam int WGT_FRAC   = 16;
    localparam int WGT_W      = WGT_FRAC + 1;
    localparam int PROD_W     = CH_W + WGT_W;

    localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << WGT_FRAC;
    localparam logic [WGT_W-1:0] WGT_ZERO = '0;

    // Stage layout: capture, one quotient bit per stage, weight select,
    // multiply, sum and output register.
    localparam int STG_IN   = 0;
    localparam int STG_WGT  = WGT_FRAC + 1;
    localparam int STG_MUL  = WGT_FRAC + 2;
    localparam int STG_OUT  = WGT_FRAC + 3;
    localparam int NUM_STG  = WGT_FRAC + 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR  = 2'd0,
        REG_HIGH_THR = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_END   = 2'd0,
        KIND_START = 2'd1,
        KIND_DIV   = 2'd2
    } t_kind;

endpackage

### hdl/mwpb_if.sv
// ============================================================================
// Masked wipe pixel blender channel interfaces
// Valid/ready channels for pixel input, blended output and register writes.
// ============================================================================
interface mwpb_pix_if;
    logic                          valid;
    logic                          ready;
    logic [mwpb_pkg::PIX_W-1:0]    start_pixel;
    logic [mwpb_pkg::PIX_W-1:0]    end_pixel;
    logic [mwpb_pkg::MASK_W-1:0]   mask_level;

    modport source (output valid, output start_pixel, output end_pixel,
                    output mask_level, input ready);
    modport sink   (input valid, input start_pixel, input end_pixel,
                    input mask_level, output ready);
endinterface

interface mwpb_out_if;
    logic                          valid;
    logic                          ready;
    logic [mwpb_pkg::PIX_W-1:0]    blended_pixel;

    modport source (output valid, output blended_pixel, input ready);
    modport sink   (input valid, input blended_pixel, output ready);
endinterface

interface mwpb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mwpb_pkg::CFG_IDX_W-1:0]  index;
    logic [mwpb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/masked_wipe_pixel_blender.sv
// ============================================================================
// Masked wipe pixel blender
// Blends a start and an end ARGB pixel with a weight derived from a wipe
// mask byte against two software-written thresholds.
// ============================================================================
// The block takes one pixel per clock while the output is not held off. Each
// pixel passes through the restoring divider that yields one quotient bit of
// the Q1.16 weight per pipeline stage, followed by weight select, multiply and
// sum stages. Each stage advances on its own, so bubbles close up behind a
// stalled output and new pixels are taken while a finished result waits. The
// user must write thresholds through the configuration channel only while the
// pipeline is empty; the block itself does not enforce this.
module masked_wipe_pixel_blender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwpb_cfg_if.sink    i_cfg,
    mwpb_pix_if.sink    i_pix,
    mwpb_out_if.source  o_res
);

    localparam int CW = mwpb_pkg::CH_W;
    localparam int FB = mwpb_pkg::WGT_FRAC;

    // Configuration registers.
    logic [mwpb_pkg::THR_W-1:0] r_low_thr;
    logic [mwpb_pkg::THR_W-1:0] r_high_thr;
    logic [mwpb_pkg::DEN_W-1:0] r_den;

    // Pipeline control.
    logic [mwpb_pkg::NUM_STG-1:0] r_vld;
    logic [mwpb_pkg::NUM_STG-1:0] stg_en;

    // Pixel payload travels up to the multiply stage.
    logic [mwpb_pkg::PIX_W-1:0]  r_start [mwpb_pkg::STG_MUL];
    logic [mwpb_pkg::PIX_W-1:0]  r_end   [mwpb_pkg::STG_MUL];
    // Division state travels up to the weight stage.
    mwpb_pkg::t_kind             r_kind  [mwpb_pkg::STG_WGT];
    logic [mwpb_pkg::DEN_W-1:0]  r_rem   [mwpb_pkg::STG_WGT];
    logic [FB-1:0]               r_quo   [mwpb_pkg::STG_WGT];

    logic [mwpb_pkg::WGT_W-1:0]  r_wgt;
    logic [mwpb_pkg::WGT_W-1:0]  r_inv;
    logic [mwpb_pkg::PROD_W-1:0] r_prod_s [mwpb_pkg::NUM_CH];
    logic [mwpb_pkg::PROD_W-1:0] r_prod_e [mwpb_pkg::NUM_CH];
    logic [mwpb_pkg::PIX_W-1:0]  r_blend;

    // Input classification.
    logic signed [mwpb_pkg::ARITH_W-1:0] mask_s;
    logic signed [mwpb_pkg::ARITH_W-1:0] low_s;
    logic signed [mwpb_pkg::ARITH_W-1:0] high_s;
    logic signed [mwpb_pkg::ARITH_W-1:0] num_s;
    logic signed [mwpb_pkg::ARITH_W-1:0] den_s;
    mwpb_pkg::t_kind                     n_kind;
    logic [mwpb_pkg::DEN_W-1:0]          n_rem0;

    // Divider steps.
    logic [mwpb_pkg::DEN_W:0]    step_dbl [1:FB];
    logic                        step_ge  [1:FB];
    logic [mwpb_pkg::DEN_W-1:0]  n_rem    [1:FB];
    logic [FB-1:0]               n_quo    [1:FB];

    logic [mwpb_pkg::WGT_W-1:0]  n_wgt;
    logic [mwpb_pkg::PROD_W-1:0] blend_sum [mwpb_pkg::NUM_CH];

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    assign low_s  = {r_low_thr[mwpb_pkg::THR_W-1], r_low_thr};
    assign high_s = {r_high_thr[mwpb_pkg::THR_W-1], r_high_thr};
    assign den_s  = high_s - low_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= '0;
            r_high_thr <= '0;
            r_den      <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mwpb_pkg::REG_LOW_THR:  r_low_thr  <= i_cfg.data;
                    mwpb_pkg::REG_HIGH_THR: r_high_thr <= i_cfg.data;
                    default: ;
                endcase
            end
            // Only meaningful when low < high, where it fits in DEN_W bits.
            r_den <= den_s[mwpb_pkg::DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage advance: a stage moves when it is empty or its successor moves.
    // ------------------------------------------------------------------------
    always_comb begin
        stg_en[mwpb_pkg::NUM_STG-1] = !r_vld[mwpb_pkg::NUM_STG-1] || o_res.ready;
        for (int i = mwpb_pkg::NUM_STG - 2; i >= 0; i--) begin
            stg_en[i] = !r_vld[i] || stg_en[i+1];
        end
    end

    assign i_pix.ready         = stg_en[mwpb_pkg::STG_IN];
    assign o_res.valid         = r_vld[mwpb_pkg::STG_OUT];
    assign o_res.blended_pixel = r_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[mwpb_pkg::STG_IN]) begin
                r_vld[mwpb_pkg::STG_IN] <= i_pix.valid;
            end
            for (int i = 1; i < mwpb_pkg::NUM_STG; i++) begin
                if (stg_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Capture stage: classify the mask against the thresholds.
    // ------------------------------------------------------------------------
    assign mask_s = $signed({{(mwpb_pkg::ARITH_W - mwpb_pkg::MASK_W){1'b0}},
                             i_pix.mask_level});
    assign num_s  = high_s - mask_s;

    always_comb begin
        n_rem0 = '0;
        if (mask_s <= low_s) begin
            n_kind = mwpb_pkg::KIND_END;
        end else if (mask_s >= high_s) begin
            n_kind = mwpb_pkg::KIND_START;
        end else begin
            // Here 0 < high - mask < high - low, so the quotient has no
            // integer part and the start remainder is the numerator itself.
            n_kind = mwpb_pkg::KIND_DIV;
            n_rem0 = num_s[mwpb_pkg::DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Restoring division, one quotient bit per stage.
    // ------------------------------------------------------------------------
    always_comb begin
        for (int k = 1; k <= FB; k++) begin
            step_dbl[k] = {r_rem[k-1], 1'b0};
            step_ge[k]  = step_dbl[k] >= {1'b0, r_den};
            if (step_ge[k]) begin
                n_rem[k] = mwpb_pkg::DEN_W'(step_dbl[k] - {1'b0, r_den});
            end else begin
                n_rem[k] = step_dbl[k][mwpb_pkg::DEN_W-1:0];
            end
            n_quo[k] = {r_quo[k-1][FB-2:0], step_ge[k]};
        end
    end

    always_comb begin
        case (r_kind[FB])
            mwpb_pkg::KIND_END:   n_wgt = mwpb_pkg::WGT_ONE;
            mwpb_pkg::KIND_START: n_wgt = mwpb_pkg::WGT_ZERO;
            default:              n_wgt = {1'b0, r_quo[FB]};
        endcase
    end

    always_comb begin
        for (int c = 0; c < mwpb_pkg::NUM_CH; c++) begin
            blend_sum[c] = r_prod_s[c] + r_prod_e[c];
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (stg_en[mwpb_pkg::STG_IN]) begin
            r_start[mwpb_pkg::STG_IN] <= i_pix.start_pixel;
            r_end[mwpb_pkg::STG_IN]   <= i_pix.end_pixel;
            r_kind[mwpb_pkg::STG_IN]  <= n_kind;
            r_rem[mwpb_pkg::STG_IN]   <= n_rem0;
            r_quo[mwpb_pkg::STG_IN]   <= '0;
        end
        for (int k = 1; k <= FB; k++) begin
            if (stg_en[k]) begin
                r_start[k] <= r_start[k-1];
                r_end[k]   <= r_end[k-1];
                r_kind[k]  <= r_kind[k-1];
                r_rem[k]   <= n_rem[k];
                r_quo[k]   <= n_quo[k];
            end
        end
        if (stg_en[mwpb_pkg::STG_WGT]) begin
            r_start[mwpb_pkg::STG_WGT] <= r_start[FB];
            r_end[mwpb_pkg::STG_WGT]   <= r_end[FB];
            r_wgt                      <= n_wgt;
            r_inv                      <= mwpb_pkg::WGT_ONE - n_wgt;
        end
        if (stg_en[mwpb_pkg::STG_MUL]) begin
            for (int c = 0; c < mwpb_pkg::NUM_CH; c++) begin
                r_prod_s[c] <= mwpb_pkg::PROD_W'(r_start[mwpb_pkg::STG_WGT][c*CW +: CW])
                             * mwpb_pkg::PROD_W'(r_inv);
                r_prod_e[c] <= mwpb_pkg::PROD_W'(r_end[mwpb_pkg::STG_WGT][c*CW +: CW])
                             * mwpb_pkg::PROD_W'(r_wgt);
            end
        end
        if (stg_en[mwpb_pkg::STG_OUT]) begin
            for (int c = 0; c < mwpb_pkg::NUM_CH; c++) begin
                r_blend[c*CW +: CW] <= blend_sum[c][FB +: CW];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[mwpb_pkg::STG_IN])
        else $error("transferred pixel did not enter the first stage");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[mwpb_pkg::STG_OUT] |-> i_pix.ready)
        else $error("input held off while the output register is empty");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[FB] && (r_kind[FB] == mwpb_pkg::KIND_DIV)) |-> (r_rem[FB] < r_den))
        else $error("divider remainder not below divisor");

    a_div_weight_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[FB] && (r_kind[FB] == mwpb_pkg::KIND_DIV)) |-> (r_quo[FB] != '0))
        else $error("blend weight inside the ramp came out zero");

endmodule

### verif/masked_wipe_pixel_blender_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Masked wipe pixel blender testbench
// Walks a directed table of threshold writes and pixels, then random phases
// with fresh thresholds, and checks every blended pixel against a predictor.
// ============================================================================
module masked_wipe_pixel_blender_test;

    typedef longint unsigned t_u64;

    typedef enum logic {
        ROW_WRITE = 1'b0,
        ROW_PIXEL = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [mwpb_pkg::CFG_IDX_W-1:0]     index;
        logic [mwpb_pkg::THR_W-1:0]         data;
        logic [mwpb_pkg::PIX_W-1:0]         start_pixel;
        logic [mwpb_pkg::PIX_W-1:0]         end_pixel;
        logic [mwpb_pkg::MASK_W-1:0]        mask_level;
        logic                               typed;
        logic [mwpb_pkg::PIX_W-1:0]         want;
    } t_dir_row;

    typedef struct {
        logic [mwpb_pkg::PIX_W-1:0]  start_pixel;
        logic [mwpb_pkg::PIX_W-1:0]  end_pixel;
        logic [mwpb_pkg::MASK_W-1:0] mask_level;
        logic [mwpb_pkg::PIX_W-1:0]  blended_pixel;
    } t_blend_expect;

    // Indexes that map to no register.
    localparam logic [mwpb_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_A = 2'd2;
    localparam logic [mwpb_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_B = 2'd3;

    localparam int IDLE_PCT       = 28;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int QUIET_PHASE    = 4;
    localparam int DRAIN_PHASE    = 2;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 100;
    localparam int NUM_DIR_ROWS   = 31;

    localparam logic [mwpb_pkg::THR_W-1:0] THR_MIN = 11'h600;   // -512
    localparam logic [mwpb_pkg::THR_W-1:0] THR_MAX = 11'h2FF;   // 767
    localparam logic [mwpb_pkg::THR_W-1:0] THR_NEG1 = 11'h7FF;  // -1

    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        // Reset thresholds: mask zero shows the end pixel, anything else the start.
        '{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 32'h00000000, 8'h00, 1'b1, 32'h00000000},
        '{ROW_PIXEL, '0, '0, 32'h12345678, 32'h9ABCDEF0, 8'hFF, 1'b1, 32'h12345678},
        '{ROW_PIXEL, '0, '0, 32'hA5A5A5A5, 32'h5A5A5A5A, 8'h01, 1'b1, 32'hA5A5A5A5},
        // Writes to unmapped indexes leave the thresholds alone.
        '{ROW_WRITE, IDX_UNMAPPED_A, 11'h7FF, '0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, IDX_UNMAPPED_B, 11'h400, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h00FF00FF, 32'hFF00FF00, 8'h00, 1'b1, 32'hFF00FF00},
        '{ROW_PIXEL, '0, '0, 32'h00FF00FF, 32'hFF00FF00, 8'h80, 1'b1, 32'h00FF00FF},
        // Widest window: every mask level goes through the divider.
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, THR_MIN, '0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_HIGH_THR, THR_MAX, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h00000000, 32'hFFFFFFFF, 8'h00, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 32'h00000000, 8'hFF, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h80808080, 32'h7F7F7F7F, 8'h80, 1'b0, '0},
        // Crossed thresholds: every mask is at or below low.
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, THR_MAX, '0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_HIGH_THR, THR_MIN, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h11223344, 32'h55667788, 8'h00, 1'b1, 32'h55667788},
        '{ROW_PIXEL, '0, '0, 32'h11223344, 32'h55667788, 8'hFF, 1'b1, 32'h55667788},
        // Equal thresholds below the mask range: always the start pixel.
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, THR_MIN, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'hCAFEBABE, 32'hDEADBEEF, 8'h00, 1'b1, 32'hCAFEBABE},
        '{ROW_PIXEL, '0, '0, 32'hCAFEBABE, 32'hDEADBEEF, 8'hFF, 1'b1, 32'hCAFEBABE},
        // Adjacent thresholds: no level falls strictly between them.
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, 11'd100, '0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_HIGH_THR, 11'd101, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h01020304, 32'hF0E0D0C0, 8'd100, 1'b1, 32'hF0E0D0C0},
        '{ROW_PIXEL, '0, '0, 32'h01020304, 32'hF0E0D0C0, 8'd101, 1'b1, 32'h01020304},
        '{ROW_PIXEL, '0, '0, 32'h01020304, 32'hF0E0D0C0, 8'd99,  1'b1, 32'hF0E0D0C0},
        '{ROW_WRITE, mwpb_pkg::REG_HIGH_THR, 11'd102, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 32'h00000000, 8'd101, 1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, 11'd0, '0, '0, '0, 1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_HIGH_THR, 11'd255, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'hFFFFFFFF, 32'h00000000, 8'd1,   1'b0, '0},
        '{ROW_WRITE, mwpb_pkg::REG_LOW_THR, THR_NEG1, '0, '0, '0, 1'b0, '0},
        '{ROW_PIXEL, '0, '0, 32'h00000000, 32'hFFFFFFFF, 8'd0,   1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mwpb_cfg_if cfg_bus ();
    mwpb_pix_if pix_bus ();
    mwpb_out_if res_bus ();

    masked_wipe_pixel_blender dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    t_blend_expect              pending_blends [$];
    logic [mwpb_pkg::THR_W-1:0] cur_low;
    logic [mwpb_pkg::THR_W-1:0] cur_high;
    int                         mismatch_count = 0;
    int                         stall_cycles = 0;
    bit                         quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    function automatic logic [mwpb_pkg::PIX_W-1:0] blend_pixel(
        input logic [mwpb_pkg::PIX_W-1:0]  s,
        input logic [mwpb_pkg::PIX_W-1:0]  e,
        input logic [mwpb_pkg::MASK_W-1:0] m,
        input logic [mwpb_pkg::THR_W-1:0]  lo_r,
        input logic [mwpb_pkg::THR_W-1:0]  hi_r);
        int                         lo;
        int                         hi;
        int                         mi;
        t_u64                       w;
        t_u64                       a;
        t_u64                       b;
        t_u64                       v;
        logic [mwpb_pkg::PIX_W-1:0] r;
        lo = $signed(lo_r);
        hi = $signed(hi_r);
        mi = m;
        if (mi <= lo) begin
            w = mwpb_pkg::WGT_ONE;
        end else if (mi >= hi) begin
            w = 0;
        end else begin
            w = (t_u64'(hi - mi) << mwpb_pkg::WGT_FRAC) / t_u64'(hi - lo);
        end
        r = '0;
        for (int ch = 0; ch < mwpb_pkg::NUM_CH; ch++) begin
            a = s[ch*mwpb_pkg::CH_W +: mwpb_pkg::CH_W];
            b = e[ch*mwpb_pkg::CH_W +: mwpb_pkg::CH_W];
            v = (a * (t_u64'(mwpb_pkg::WGT_ONE) - w) + b * w) >> mwpb_pkg::WGT_FRAC;
            r[ch*mwpb_pkg::CH_W +: mwpb_pkg::CH_W] = v[mwpb_pkg::CH_W-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Lowers the pixel valid and holds off until every blended pixel is back.
    task automatic wait_drain();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (pending_blends.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [mwpb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mwpb_pkg::THR_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) begin
            @(posedge i_clk);
        end
        if (idx == mwpb_pkg::REG_LOW_THR) begin
            cur_low = val;
        end else if (idx == mwpb_pkg::REG_HIGH_THR) begin
            cur_high = val;
        end
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Valid stays high after the transfer; the next call or wait_drain
    // decides its level at the following falling edge.
    task automatic send_pixel(input logic [mwpb_pkg::PIX_W-1:0] s,
                              input logic [mwpb_pkg::PIX_W-1:0] e,
                              input logic [mwpb_pkg::MASK_W-1:0] m,
                              input logic [mwpb_pkg::PIX_W-1:0] want);
        t_blend_expect item;
        item.start_pixel   = s;
        item.end_pixel     = e;
        item.mask_level    = m;
        item.blended_pixel = want;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.start_pixel <= s;
        pix_bus.end_pixel   <= e;
        pix_bus.mask_level  <= m;
        @(posedge i_clk);
        while (!pix_bus.ready) begin
            @(posedge i_clk);
        end
        pending_blends.push_back(item);
    endtask

    always @(negedge i_clk) begin
        res_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_blend_expect head;
        if (i_rst_n === 1'b1 && res_bus.valid && res_bus.ready) begin
            if (pending_blends.size() == 0) begin
                flag_mismatch($sformatf("unexpected blended pixel %08h", res_bus.blended_pixel));
            end else begin
                head = pending_blends.pop_front();
                if (res_bus.blended_pixel !== head.blended_pixel) begin
                    flag_mismatch($sformatf(
                        "start %08h end %08h mask %02h: blended %08h, expected %08h",
                        head.start_pixel, head.end_pixel, head.mask_level,
                        res_bus.blended_pixel, head.blended_pixel));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int                          total;
        int                          phase;
        int                          n;
        int                          kind;
        int                          lo_i;
        int                          hi_i;
        int                          m_i;
        logic [mwpb_pkg::PIX_W-1:0]  s;
        logic [mwpb_pkg::PIX_W-1:0]  e;
        logic [mwpb_pkg::MASK_W-1:0] m_v;
        logic [mwpb_pkg::THR_W-1:0]  lo_v;
        logic [mwpb_pkg::THR_W-1:0]  hi_v;
        i_rst_n             = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = mwpb_pkg::REG_LOW_THR;
        cfg_bus.data        = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.start_pixel = '0;
        pix_bus.end_pixel   = '0;
        pix_bus.mask_level  = '0;
        res_bus.ready       = 1'b0;
        cur_low             = '0;
        cur_high            = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            if (DIR_ROWS[i].kind == ROW_WRITE) begin
                wait_drain();
                write_reg(DIR_ROWS[i].index, DIR_ROWS[i].data);
            end else begin
                send_pixel(DIR_ROWS[i].start_pixel, DIR_ROWS[i].end_pixel,
                           DIR_ROWS[i].mask_level,
                           DIR_ROWS[i].typed ? DIR_ROWS[i].want :
                           blend_pixel(DIR_ROWS[i].start_pixel, DIR_ROWS[i].end_pixel,
                                       DIR_ROWS[i].mask_level, cur_low, cur_high));
            end
        end

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            wait_drain();
            kind = $urandom_range(5);
            case (kind)
                0: begin
                    lo_v = mwpb_pkg::THR_W'($urandom);
                    hi_v = mwpb_pkg::THR_W'($urandom);
                end
                1: begin
                    lo_i = $urandom_range(220) - 20;
                    hi_i = lo_i + $urandom_range(60, 1);
                    lo_v = mwpb_pkg::THR_W'(lo_i);
                    hi_v = mwpb_pkg::THR_W'(hi_i);
                end
                2: begin
                    lo_v = $urandom_range(1) ? THR_MAX : THR_MIN;
                    hi_v = $urandom_range(1) ? THR_MAX : THR_MIN;
                end
                3: begin
                    lo_v = mwpb_pkg::THR_W'($urandom_range(300) - 20);
                    hi_v = lo_v;
                end
                4: begin
                    hi_i = $urandom_range(300) - 20;
                    lo_i = hi_i + $urandom_range(80);
                    lo_v = mwpb_pkg::THR_W'(lo_i);
                    hi_v = mwpb_pkg::THR_W'(hi_i);
                end
                default: begin
                    lo_v = mwpb_pkg::THR_W'(-int'($urandom_range(512)));
                    hi_v = mwpb_pkg::THR_W'($urandom_range(767, 255));
                end
            endcase
            write_reg(mwpb_pkg::REG_LOW_THR, lo_v);
            write_reg(mwpb_pkg::REG_HIGH_THR, hi_v);
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? IDX_UNMAPPED_A : IDX_UNMAPPED_B,
                          mwpb_pkg::THR_W'($urandom));
            end
            quiet = (phase == QUIET_PHASE);
            n = $urandom_range(120, 40);
            for (int i = 0; i < n; i++) begin
                if (phase == DRAIN_PHASE && i == n / 2) begin
                    wait_drain();
                end
                s = $urandom;
                e = $urandom;
                // Part of the masks land right around one of the thresholds.
                if ($urandom_range(9) < 3) begin
                    m_i = ($urandom_range(1) ? int'($signed(cur_low)) : int'($signed(cur_high)))
                          + $urandom_range(4) - 2;
                    m_i = (m_i < 0) ? 0 : ((m_i > 255) ? 255 : m_i);
                end else begin
                    m_i = $urandom_range(255);
                end
                m_v = mwpb_pkg::MASK_W'(m_i);
                send_pixel(s, e, m_v, blend_pixel(s, e, m_v, cur_low, cur_high));
            end
            total += n;
            phase++;
        end

        quiet = 1'b0;
        wait_drain();
        repeat (2 * mwpb_pkg::NUM_STG) @(posedge i_clk);
        if (mismatch_count == 0 && pending_blends.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
